### sv/boyer_moore_table_builder_core_defines.svh
// ----------------------------------------------------------------------------
// boyer_moore_table_builder_core_defines
// assertion macros used by the checker file of the table builder
// ----------------------------------------------------------------------------
`ifndef BOYER_MOORE_TABLE_BUILDER_CORE_DEFINES_SVH
`define BOYER_MOORE_TABLE_BUILDER_CORE_DEFINES_SVH

// clocked assertion, switched off while reset is low
`define BMTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
  else $error(msg);

// clocked assertion that also holds during reset
`define BMTB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### sv/bmtb_pkg.sv
// ----------------------------------------------------------------------------
// bmtb_pkg
// types, codes and helpers of the boyer-moore table builder
// ----------------------------------------------------------------------------
package bmtb_pkg;

  localparam int ALPHABET   = 256;
  localparam int CHAR_W     = 8;
  localparam int SHIFT_W    = 9;
  localparam int LEN_W      = 9;
  localparam int POS_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [1:0] {
    OPC_WRITE   = 2'd0,
    OPC_BUILD   = 2'd1,
    OPC_RD_BAD  = 2'd2,
    OPC_RD_GOOD = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_LENGTH  = 2'd0,
    CFG_FORWARD = 2'd1,
    CFG_CASE    = 2'd2
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RDWAIT, ST_BCF, ST_INIT_RD, ST_INIT_WR,
    ST_K_BL, ST_K_RA, ST_K_CHK, ST_K_RB, ST_K_UPD, ST_K_DEC,
    ST_P1_RD, ST_P1_WR, ST_P2_BL, ST_P2_LD, ST_P2_LOOP, ST_P2_WR,
    ST_FIN, ST_DONE
  } ctrl_state_e;

  typedef enum logic [4:0] {
    OP_ACCEPT, OP_RDWAIT, OP_BCF, OP_INIT_RD, OP_INIT_WR,
    OP_K_BL, OP_K_RA, OP_K_CHK, OP_K_RB, OP_K_UPD, OP_K_DEC,
    OP_P1_RD, OP_P1_WR, OP_P2_BL, OP_P2_LD, OP_P2_LOOP, OP_P2_WR,
    OP_FIN, OP_NONE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   accept;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic build_ok;
    logic read_ok;
    logic sweep_last;
    logic i_zero;
    logic i_lt_len;
    logic t_le_len;
    logic chars_eq;
    logic k_lt_t;
    logic t_le_i;
  } dp_stat_t;

  // ascii upper case to lower case when folding is on
  function automatic logic [CHAR_W-1:0] fold_char(logic [CHAR_W-1:0] c, logic case_sens);
    logic [CHAR_W-1:0] r;
    r = c;
    if (!case_sens && (c inside {[8'h41:8'h5A]})) begin
      r = c + CHAR_W'(32);
    end
    return r;
  endfunction

endpackage

### sv/bmtb_ram.sv
// ----------------------------------------------------------------------------
// bmtb_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module bmtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### sv/bmtb_ctrl.sv
// ----------------------------------------------------------------------------
// bmtb_ctrl
// command sequencer: decodes words and steps the table build
// ----------------------------------------------------------------------------
module bmtb_ctrl
  import bmtb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  dp_stat_t    stat_i,
  output dp_cmd_t     cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (opcode_e'(opcode_i))
            OPC_WRITE:   state_d = ST_DONE;
            OPC_BUILD:   state_d = stat_i.build_ok ? ST_BCF : ST_DONE;
            OPC_RD_BAD,
            OPC_RD_GOOD: state_d = stat_i.read_ok ? ST_RDWAIT : ST_DONE;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_RDWAIT:  state_d = ST_DONE;
      ST_BCF:     state_d = stat_i.sweep_last ? ST_INIT_RD : ST_BCF;
      ST_INIT_RD: state_d = stat_i.i_lt_len ? ST_INIT_WR : ST_K_BL;
      ST_INIT_WR: state_d = ST_INIT_RD;
      ST_K_BL:    state_d = stat_i.i_zero ? ST_P1_RD : ST_K_RA;
      ST_K_RA:    state_d = ST_K_CHK;
      ST_K_CHK:   state_d = stat_i.t_le_len ? ST_K_RB : ST_K_DEC;
      ST_K_RB:    state_d = stat_i.chars_eq ? ST_K_DEC : ST_K_UPD;
      ST_K_UPD:   state_d = ST_K_CHK;
      ST_K_DEC:   state_d = ST_K_BL;
      ST_P1_RD:   state_d = stat_i.k_lt_t ? ST_P1_WR : ST_P2_BL;
      ST_P1_WR:   state_d = ST_P1_RD;
      ST_P2_BL:   state_d = ST_P2_LD;
      ST_P2_LD:   state_d = stat_i.t_le_len ? ST_P2_LOOP : ST_FIN;
      ST_P2_LOOP: begin
        if (stat_i.t_le_i) begin
          state_d = ST_P2_WR;
        end else if (!stat_i.t_le_len) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_P2_LD;
        end
      end
      ST_P2_WR:   state_d = ST_P2_LOOP;
      ST_FIN:     state_d = ST_DONE;
      ST_DONE:    state_d = slot_free ? ST_IDLE : ST_DONE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o.accept   = 1'b0;
    cmd_o.out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.op     = OP_ACCEPT;
        cmd_o.accept = in_valid_i;
      end
      ST_RDWAIT:  cmd_o.op = OP_RDWAIT;
      ST_BCF:     cmd_o.op = OP_BCF;
      ST_INIT_RD: cmd_o.op = OP_INIT_RD;
      ST_INIT_WR: cmd_o.op = OP_INIT_WR;
      ST_K_BL:    cmd_o.op = OP_K_BL;
      ST_K_RA:    cmd_o.op = OP_K_RA;
      ST_K_CHK:   cmd_o.op = OP_K_CHK;
      ST_K_RB:    cmd_o.op = OP_K_RB;
      ST_K_UPD:   cmd_o.op = OP_K_UPD;
      ST_K_DEC:   cmd_o.op = OP_K_DEC;
      ST_P1_RD:   cmd_o.op = OP_P1_RD;
      ST_P1_WR:   cmd_o.op = OP_P1_WR;
      ST_P2_BL:   cmd_o.op = OP_P2_BL;
      ST_P2_LD:   cmd_o.op = OP_P2_LD;
      ST_P2_LOOP: cmd_o.op = OP_P2_LOOP;
      ST_P2_WR:   cmd_o.op = OP_P2_WR;
      ST_FIN:     cmd_o.op = OP_FIN;
      ST_DONE: begin
        cmd_o.op       = OP_NONE;
        cmd_o.out_load = slot_free;
      end
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### sv/bmtb_dp.sv
// ----------------------------------------------------------------------------
// bmtb_dp
// datapath: config registers, pattern store, shift tables and build counters
// ----------------------------------------------------------------------------
module bmtb_dp
  import bmtb_pkg::*;
#(
  parameter int MAX_PATTERN = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [1:0]            opcode_i,
  input  logic [POS_W-1:0]      position_i,
  input  logic [CHAR_W-1:0]     pattern_byte_i,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o,
  output logic [SHIFT_W-1:0]    shift_value_o,
  output logic [1:0]            status_o
);

  localparam int SAW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int GIW = $clog2(MAX_PATTERN + 1);
  localparam int GW  = $clog2(2 * MAX_PATTERN);
  localparam int BW  = $clog2(MAX_PATTERN + 1);
  localparam int BLW = $clog2(MAX_PATTERN + 2);
  localparam int CWA = $clog2(2 * MAX_PATTERN + 2);
  localparam int CW  = (CWA > LEN_W + 1) ? CWA : LEN_W + 1;

  // config and status registers
  logic [LEN_W-1:0]   len_q, len_d;
  logic               fwd_q, fwd_d;
  logic               cs_q, cs_d;
  logic               valid_q, valid_d;
  logic [LEN_W-1:0]   built_q, built_d;
  // work registers
  opcode_e            opc_q, opc_d;
  logic [CW-1:0]      i_q, i_d;
  logic [CW-1:0]      t_q, t_d;
  logic [CHAR_W-1:0]  a_q, a_d;
  logic [SHIFT_W-1:0] res_val_q, res_val_d;
  status_e            res_sts_q, res_sts_d;
  logic [SHIFT_W-1:0] out_val_q, out_val_d;
  status_e            out_sts_q, out_sts_d;

  // memory ports
  logic              st_we, st_re;
  logic [SAW-1:0]    st_waddr, st_raddr;
  logic [CHAR_W-1:0] st_wdata, st_rdata;
  logic              bc_we, bc_re;
  logic [CHAR_W-1:0] bc_waddr, bc_raddr;
  logic [BW-1:0]     bc_wdata, bc_rdata;
  logic              gs_we, gs_re;
  logic [GIW-1:0]    gs_waddr, gs_raddr;
  logic [GW-1:0]     gs_wdata, gs_rdata;
  logic              bl_we, bl_re;
  logic [GIW-1:0]    bl_waddr, bl_raddr;
  logic [BLW-1:0]    bl_wdata, bl_rdata;

  logic [CW-1:0]     len_c;
  logic [CHAR_W-1:0] st_char;
  logic              pos_in_store;

  assign len_c        = CW'(len_q);
  assign st_char      = fold_char(st_rdata, cs_q);
  assign pos_in_store = CW'(position_i) < CW'(MAX_PATTERN);

  // working pattern index to store address, reversed when asked
  function automatic logic [SAW-1:0] map_addr(logic [CW-1:0] k, logic [CW-1:0] n,
                                               logic fwd);
    logic [CW-1:0] a;
    a = fwd ? k : (n - k - CW'(1));
    return SAW'(a);
  endfunction

  function automatic logic [GW-1:0] min_gs(logic [GW-1:0] cur, logic [CW-1:0] cand);
    return (cand < CW'(cur)) ? GW'(cand) : cur;
  endfunction

  // status towards the sequencer
  always_comb begin
    stat_o.build_ok   = (len_q != '0) && (len_c <= CW'(MAX_PATTERN));
    stat_o.read_ok    = valid_q && ((opcode_e'(opcode_i) == OPC_RD_BAD) ||
                                    (position_i <= built_q));
    stat_o.sweep_last = (i_q == CW'(ALPHABET - 1));
    stat_o.i_zero     = (i_q == '0);
    stat_o.i_lt_len   = (i_q < len_c);
    stat_o.t_le_len   = (t_q <= len_c);
    stat_o.chars_eq   = (a_q == st_char);
    stat_o.k_lt_t     = (i_q < t_q);
    stat_o.t_le_i     = (t_q <= i_q);
  end

  // per-command datapath actions
  always_comb begin
    len_d     = len_q;
    fwd_d     = fwd_q;
    cs_d      = cs_q;
    valid_d   = valid_q;
    built_d   = built_q;
    opc_d     = opc_q;
    i_d       = i_q;
    t_d       = t_q;
    a_d       = a_q;
    res_val_d = res_val_q;
    res_sts_d = res_sts_q;
    out_val_d = out_val_q;
    out_sts_d = out_sts_q;

    st_we    = 1'b0;
    st_waddr = SAW'(position_i);
    st_wdata = pattern_byte_i;
    st_re    = 1'b0;
    st_raddr = map_addr(i_q, len_c, fwd_q);
    bc_we    = 1'b0;
    bc_waddr = CHAR_W'(i_q);
    bc_wdata = BW'(len_c);
    bc_re    = 1'b0;
    bc_raddr = pattern_byte_i;
    gs_we    = 1'b0;
    gs_waddr = GIW'(i_q);
    gs_wdata = GW'(len_c + len_c - i_q - CW'(1));
    gs_re    = 1'b0;
    gs_raddr = GIW'(position_i);
    bl_we    = 1'b0;
    bl_waddr = GIW'(i_q - CW'(1));
    bl_wdata = BLW'(t_q);
    bl_re    = 1'b0;
    bl_raddr = GIW'(t_q - CW'(1));

    // configuration writes
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LENGTH:  len_d = cfg_data_i;
        CFG_FORWARD: fwd_d = cfg_data_i[0];
        CFG_CASE:    cs_d  = cfg_data_i[0];
        default:     ;
      endcase
    end

    case (cmd_i.op)
      OP_ACCEPT: begin
        if (cmd_i.accept) begin
          opc_d     = opcode_e'(opcode_i);
          res_val_d = '0;
          res_sts_d = STS_OK;
          bc_re     = 1'b1;
          gs_re     = 1'b1;
          case (opcode_e'(opcode_i))
            OPC_WRITE: begin
              if (pos_in_store) begin
                st_we = 1'b1;
              end else begin
                res_sts_d = STS_RANGE;
              end
            end
            OPC_BUILD: begin
              i_d = '0;
              if (len_q == '0) begin
                valid_d   = 1'b0;
                res_sts_d = STS_EMPTY;
              end else if (!stat_o.build_ok) begin
                valid_d   = 1'b0;
                res_sts_d = STS_RANGE;
              end
            end
            OPC_RD_BAD: begin
              if (!valid_q) begin
                res_sts_d = STS_EMPTY;
              end
            end
            OPC_RD_GOOD: begin
              if (!valid_q) begin
                res_sts_d = STS_EMPTY;
              end else if (position_i > built_q) begin
                res_sts_d = STS_RANGE;
              end
            end
            default: ;
          endcase
        end
      end
      OP_RDWAIT: begin
        res_val_d = (opc_q == OPC_RD_BAD) ? SHIFT_W'(bc_rdata) : SHIFT_W'(gs_rdata);
      end
      // every bad-character entry starts at the pattern length
      OP_BCF: begin
        bc_we = 1'b1;
        i_d   = stat_o.sweep_last ? '0 : i_q + CW'(1);
      end
      // good-suffix start value and pattern byte fetch
      OP_INIT_RD: begin
        gs_we = 1'b1;
        st_re = 1'b1;
        t_d   = len_c + CW'(1);
      end
      OP_INIT_WR: begin
        bc_we    = 1'b1;
        bc_waddr = st_char;
        bc_wdata = BW'(len_c - i_q - CW'(1));
        i_d      = i_q + CW'(1);
      end
      // border scan from the end of the pattern
      OP_K_BL: begin
        bl_we    = !stat_o.i_zero;
        st_re    = !stat_o.i_zero;
        st_raddr = map_addr(i_q - CW'(1), len_c, fwd_q);
      end
      OP_K_RA: begin
        a_d = st_char;
      end
      OP_K_CHK: begin
        st_re    = 1'b1;
        st_raddr = map_addr(t_q - CW'(1), len_c, fwd_q);
      end
      OP_K_RB: begin
        gs_re    = 1'b1;
        gs_raddr = GIW'(t_q - CW'(1));
        bl_re    = 1'b1;
      end
      OP_K_UPD: begin
        gs_we    = 1'b1;
        gs_waddr = GIW'(t_q - CW'(1));
        gs_wdata = min_gs(gs_rdata, len_c - i_q);
        t_d      = CW'(bl_rdata);
      end
      OP_K_DEC: begin
        i_d = i_q - CW'(1);
        t_d = t_q - CW'(1);
      end
      // prefix pass below the widest border
      OP_P1_RD: begin
        gs_re    = 1'b1;
        gs_raddr = GIW'(i_q);
      end
      OP_P1_WR: begin
        gs_we    = 1'b1;
        gs_wdata = min_gs(gs_rdata, len_c + t_q - i_q - CW'(1));
        i_d      = i_q + CW'(1);
      end
      // walk down the border chain
      OP_P2_BL: begin
        bl_re = 1'b1;
      end
      OP_P2_LD: begin
        i_d = CW'(bl_rdata);
      end
      OP_P2_LOOP: begin
        gs_re    = 1'b1;
        gs_raddr = GIW'(t_q - CW'(1));
        bl_re    = 1'b1;
        bl_raddr = GIW'(i_q - CW'(1));
      end
      OP_P2_WR: begin
        gs_we    = 1'b1;
        gs_waddr = GIW'(t_q - CW'(1));
        gs_wdata = min_gs(gs_rdata, i_q - t_q + len_c);
        t_d      = t_q + CW'(1);
      end
      OP_FIN: begin
        valid_d = 1'b1;
        built_d = len_q;
      end
      default: ;
    endcase

    // result word into the output register
    if (cmd_i.out_load) begin
      out_val_d = res_val_q;
      out_sts_d = res_sts_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      fwd_q   <= 1'b1;
      cs_q    <= 1'b1;
      valid_q <= 1'b0;
      built_q <= '0;
    end else begin
      len_q   <= len_d;
      fwd_q   <= fwd_d;
      cs_q    <= cs_d;
      valid_q <= valid_d;
      built_q <= built_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opc_q     <= opc_d;
    i_q       <= i_d;
    t_q       <= t_d;
    a_q       <= a_d;
    res_val_q <= res_val_d;
    res_sts_q <= res_sts_d;
    out_val_q <= out_val_d;
    out_sts_q <= out_sts_d;
  end

  assign shift_value_o = out_val_q;
  assign status_o      = out_sts_q;

  // pattern store
  bmtb_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_PATTERN)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // bad-character table
  bmtb_ram #(.WIDTH(BW), .DEPTH(ALPHABET)) u_bad_char (
    .clk_i   (clk_i),
    .we_i    (bc_we),
    .waddr_i (bc_waddr),
    .wdata_i (bc_wdata),
    .re_i    (bc_re),
    .raddr_i (bc_raddr),
    .rdata_o (bc_rdata)
  );

  // good-suffix table
  bmtb_ram #(.WIDTH(GW), .DEPTH(MAX_PATTERN + 1)) u_good_suffix (
    .clk_i   (clk_i),
    .we_i    (gs_we),
    .waddr_i (gs_waddr),
    .wdata_i (gs_wdata),
    .re_i    (gs_re),
    .raddr_i (gs_raddr),
    .rdata_o (gs_rdata)
  );

  // border links
  bmtb_ram #(.WIDTH(BLW), .DEPTH(MAX_PATTERN + 1)) u_border (
    .clk_i   (clk_i),
    .we_i    (bl_we),
    .waddr_i (bl_waddr),
    .wdata_i (bl_wdata),
    .re_i    (bl_re),
    .raddr_i (bl_raddr),
    .rdata_o (bl_rdata)
  );

endmodule

### sv/boyer_moore_table_builder_core.sv
// ----------------------------------------------------------------------------
// boyer_moore_table_builder_core
// builds boyer-moore bad-character and good-suffix shift tables
// ----------------------------------------------------------------------------
// Usage: the command channel (in_valid_i/in_ready_o) carries one word per
// command: write a pattern byte, build the tables, read a bad-character entry
// or read a good-suffix entry. Every command gives exactly one result word on
// the out channel (out_valid_o/out_ready_i): shift value and status.
// The config port sets pattern length, direction and case folding; write it
// only while no command is in flight.
// Timing: a write, a build refused for its length or a refused read goes from
// accept straight to the result state; a good read first waits for the table
// read. A build runs the bad-character fill, the table start values, the border
// scan and the two good-suffix passes, each paced by the single read port of
// each table memory. One command is in flight at a time.
// Reset clears the config to length 0, forward order, case sensitive, and
// marks the tables as not built; the memories are not cleared.
// When the receiver stalls, the finished word holds in the output register;
// one more command is still taken, its result waits inside, and no further
// command is taken until the held word goes out.
// ----------------------------------------------------------------------------
module boyer_moore_table_builder_core
  import bmtb_pkg::*;
#(
  parameter int MAX_PATTERN = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            opcode_i,
  input  logic [POS_W-1:0]      position_i,
  input  logic [CHAR_W-1:0]     pattern_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SHIFT_W-1:0]    shift_value_o,
  output logic [1:0]            status_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  bmtb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // tables and registers
  bmtb_dp #(.MAX_PATTERN(MAX_PATTERN)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .opcode_i       (opcode_i),
    .position_i     (position_i),
    .pattern_byte_i (pattern_byte_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .shift_value_o  (shift_value_o),
    .status_o       (status_o)
  );

endmodule

### sv/bmtb_checker.sv
// ----------------------------------------------------------------------------
// bmtb_checker
// port-level checks of the table builder, bound to the top level
// ----------------------------------------------------------------------------
`include "boyer_moore_table_builder_core_defines.svh"

module bmtb_checker
  import bmtb_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_index_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic [1:0]            opcode_i,
  input logic [POS_W-1:0]      position_i,
  input logic [CHAR_W-1:0]     pattern_byte_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [SHIFT_W-1:0]    shift_value_o,
  input logic [1:0]            status_o
);

  // a stalled result word stays put
  `BMTB_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "out word dropped")
  `BMTB_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(shift_value_o) && $stable(status_o), "out word changed")
  // one command in flight: no accept right after an accept
  `BMTB_ASSERT(a_one_cmd, in_valid_i && in_ready_o |=> !in_ready_o, "second command accepted")
  // error words carry a zero shift value
  `BMTB_ASSERT(a_err_zero, out_valid_o && (status_o != STS_OK) |-> shift_value_o == '0, "error with value")
  // no result during reset
  `BMTB_ASSERT_RST(a_rst_quiet, !rst_ni |-> !out_valid_o, "out valid in reset")

endmodule

bind boyer_moore_table_builder_core bmtb_checker u_bmtb_checker (.*);

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the boyer-moore table builder: a scoreboard class
// predicts every result word from the accepted commands and checks the
// output channel in order, under several idle and stall patterns
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import bmtb_pkg::*;

typedef struct {
  logic [SHIFT_W-1:0] shift;
  logic [1:0]         status;
} shift_word_t;

// predicts result words and checks them in order
class bm_scoreboard;
  int unsigned plen;
  bit          fwd;
  bit          case_sens;
  logic [7:0]  store [256];
  int unsigned bad_shift [256];
  int unsigned good_shift [257];
  int unsigned border [257];
  logic [7:0]  work [256];
  bit          built;
  int unsigned built_len;
  shift_word_t pending [$];
  int          errors;
  int          checked;
  int          builds_ok;

  function new();
    plen = 0;
    fwd = 1;
    case_sens = 1;
    built = 0;
    built_len = 0;
    errors = 0;
    checked = 0;
    builds_ok = 0;
  endfunction

  function void set_reg(cfg_idx_e idx, int unsigned v);
    case (idx)
      CFG_LENGTH:  plen = v & 9'h1FF;
      CFG_FORWARD: fwd = v[0];
      CFG_CASE:    case_sens = v[0];
      default: ;
    endcase
  endfunction

  function int unsigned umin(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  // bad-character and good-suffix tables of the working pattern
  function void build_tables(int unsigned len);
    int unsigned k, i, t;
    logic [7:0]  c;
    for (k = 0; k < len; k++) begin
      c = fwd ? store[k] : store[len-1-k];
      if (!case_sens && c >= 8'h41 && c <= 8'h5A) c = c + 8'd32;
      work[k] = c;
    end
    for (k = 0; k < 256; k++) bad_shift[k] = len;
    for (i = len; i > 0; i--) begin
      c = work[i-1];
      if (bad_shift[c] == len) bad_shift[c] = len - i;
      good_shift[i-1] = 2 * len - i;
    end
    good_shift[len] = len - 1;
    // border scan
    i = len;
    t = len + 1;
    while (i > 0) begin
      border[i-1] = t;
      while (t <= len && work[i-1] != work[t-1]) begin
        good_shift[t-1] = umin(good_shift[t-1], len - i);
        t = border[t-1];
      end
      i--;
      t--;
    end
    for (i = 0; i < t; i++) good_shift[i] = umin(good_shift[i], len + t - i - 1);
    i = border[t-1];
    if (t <= len) begin
      while (1) begin
        while (t <= i) begin
          good_shift[t-1] = umin(good_shift[t-1], i - t + len);
          t++;
        end
        if (t > len) break;
        i = border[i-1];
      end
    end
  endfunction

  function void note_input(opcode_e op, logic [8:0] pos, logic [7:0] b);
    shift_word_t w;
    int unsigned v;
    v = 0;
    w.status = STS_OK;
    case (op)
      OPC_WRITE: begin
        if (pos < 256) store[pos] = b;
        else w.status = STS_RANGE;
      end
      OPC_BUILD: begin
        if (plen == 0) begin
          built = 0;
          w.status = STS_EMPTY;
        end else if (plen > 256) begin
          built = 0;
          w.status = STS_RANGE;
        end else begin
          build_tables(plen);
          built_len = plen;
          built = 1;
          builds_ok++;
        end
      end
      OPC_RD_BAD: begin
        if (!built) w.status = STS_EMPTY;
        else v = bad_shift[b];
      end
      default: begin
        if (!built) w.status = STS_EMPTY;
        else if (pos > built_len) w.status = STS_RANGE;
        else v = good_shift[pos];
      end
    endcase
    w.shift = v[8:0];
    pending.push_back(w);
  endfunction

  function void check_result(logic [8:0] sv, logic [1:0] st);
    shift_word_t w;
    checked++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result word: shift %0d status %0d", sv, st);
      return;
    end
    w = pending.pop_front();
    if (sv !== w.shift || st !== w.status) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected shift %0d status %0d, got shift %0d status %0d",
                 w.shift, w.status, sv, st);
    end
  endfunction
endclass

module testbench;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASES = 40;
  localparam int PHASE_ITEMS = 18;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [1:0]            opcode_i;
  logic [POS_W-1:0]      position_i;
  logic [CHAR_W-1:0]     pattern_byte_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [SHIFT_W-1:0]    shift_value_o;
  logic [1:0]            status_o;

  bm_scoreboard sb;
  int  idle_mode;
  bit  hold_req;
  int  hold_cnt;
  int  quiet_cycles;
  int  sent;
  bit  written [256];
  int  prefix;
  bit  small_alpha;

  boyer_moore_table_builder_core dut (.*);

  // clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      out_ready_i <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req) begin
      out_ready_i <= 1'b0;
      hold_cnt <= 300;
      hold_req <= 1'b0;
    end else begin
      out_ready_i <= (idle_mode == 2 || idle_mode == 3) ? ($urandom_range(99) >= 64) : 1'b1;
    end
  end

  // result word check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(shift_value_o, status_o);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_word(opcode_e op, logic [8:0] pos, logic [7:0] b);
    int gap;
    in_valid_i <= 1'b1;
    opcode_i <= op;
    position_i <= pos;
    pattern_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(op, pos, b);
    sent++;
    if (op == OPC_WRITE && pos < 256) written[pos] = 1'b1;
    while (prefix < 256 && written[prefix]) prefix++;
    gap = 0;
    if ((idle_mode == 1 || idle_mode == 3) && $urandom_range(99) < 64) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // sender pause until every result word has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned v);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v[8:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] letters [4] = '{8'h41, 8'h42, 8'h61, 8'h62};
    if (small_alpha) return letters[$urandom_range(3)];
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [8:0] pick_good_pos();
    if ($urandom_range(9) == 0) return 9'($urandom_range(511));
    return 9'($urandom_range(sb.built_len + 2));
  endfunction

  // one random word, mostly reads of a built table
  task automatic random_word();
    int r;
    logic [8:0] pos;
    r = $urandom_range(99);
    if (r < 35) begin
      if ($urandom_range(19) == 0) pos = 9'($urandom_range(256, 511));
      else pos = 9'($urandom_range((prefix + 4 > 255) ? 255 : prefix + 4));
      send_word(OPC_WRITE, pos, pick_byte());
    end else if (r < 42) begin
      send_word(OPC_BUILD, 9'($urandom_range(511)), 8'($urandom_range(255)));
    end else if (r < 70) begin
      send_word(OPC_RD_BAD, 9'($urandom_range(511)), ($urandom_range(1) == 0) ? pick_byte() :
                8'($urandom_range(255)));
    end else begin
      send_word(OPC_RD_GOOD, pick_good_pos(), 8'($urandom_range(255)));
    end
  endtask

  initial begin
    int len;
    int k;
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    opcode_i = '0;
    position_i = '0;
    pattern_byte_i = '0;
    out_ready_i = 1'b1;
    idle_mode = 0;
    hold_req = 1'b0;
    hold_cnt = 0;
    quiet_cycles = 0;
    sent = 0;
    prefix = 0;
    small_alpha = 1'b0;
    foreach (written[i]) written[i] = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reads before any build, empty build, out of range writes
    send_word(OPC_RD_BAD, 9'd0, 8'hFF);
    send_word(OPC_RD_GOOD, 9'd0, 8'h00);
    send_word(OPC_BUILD, 9'd0, 8'h00);
    send_word(OPC_WRITE, 9'd256, 8'h11);
    send_word(OPC_WRITE, 9'd511, 8'hFF);
    send_word(OPC_WRITE, 9'd0, 8'h41);
    send_word(OPC_WRITE, 9'd1, 8'h62);
    send_word(OPC_WRITE, 9'd2, 8'h61);
    send_word(OPC_WRITE, 9'd3, 8'h42);
    drain();
    write_reg(CFG_LENGTH, 4);
    send_word(OPC_BUILD, 9'd0, 8'h00);
    send_word(OPC_RD_BAD, 9'd0, 8'h61);
    send_word(OPC_RD_BAD, 9'd0, 8'h00);
    send_word(OPC_RD_GOOD, 9'd0, 8'h00);
    send_word(OPC_RD_GOOD, 9'd4, 8'h00);
    send_word(OPC_RD_GOOD, 9'd5, 8'h00);
    // stale tables after a write
    send_word(OPC_WRITE, 9'd0, 8'hFF);
    send_word(OPC_RD_BAD, 9'd0, 8'h41);
    drain();
    write_reg(CFG_FORWARD, 0);
    write_reg(CFG_CASE, 0);
    send_word(OPC_BUILD, 9'd0, 8'h00);
    send_word(OPC_RD_BAD, 9'd0, 8'h62);
    send_word(OPC_RD_GOOD, 9'd511, 8'h00);
    drain();
    write_reg(CFG_LENGTH, 511);
    send_word(OPC_BUILD, 9'd0, 8'h00);
    send_word(OPC_RD_GOOD, 9'd1, 8'h00);
    drain();

    // random phases over all idle patterns
    for (int ph = 0; ph < PHASES; ph++) begin
      idle_mode = ph % 4;
      small_alpha = 1'($urandom_range(1));
      if (ph == PHASES - 4) begin
        // full-length pattern
        for (k = 0; k < 256; k++) send_word(OPC_WRITE, k[8:0], pick_byte());
        drain();
        len = 256;
      end else if ($urandom_range(9) == 0) begin
        len = 0;
      end else if ($urandom_range(9) == 0) begin
        len = $urandom_range(257, 511);
      end else begin
        len = $urandom_range(1, 16);
      end
      write_reg(CFG_LENGTH, len);
      write_reg(CFG_FORWARD, $urandom_range(1));
      write_reg(CFG_CASE, $urandom_range(1));
      if (ph == 6 || ph == 23) hold_req <= 1'b1;
      // fresh or completed pattern for a valid length, then build, then random traffic
      if (len >= 1 && len <= 16 && $urandom_range(3) != 0) begin
        for (k = 0; k < len; k++) send_word(OPC_WRITE, k[8:0], pick_byte());
      end else if (len >= 1 && len <= 256 && prefix < len) begin
        for (k = prefix; k < len; k++) send_word(OPC_WRITE, k[8:0], pick_byte());
      end
      send_word(OPC_BUILD, 9'd0, 8'h00);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (sb.plen >= 1 && sb.plen <= 256 && prefix < sb.plen) begin
          send_word(OPC_WRITE, prefix[8:0], pick_byte());
        end else begin
          random_word();
        end
      end
      drain();
    end

    while (hold_cnt > 0) @(posedge clk_i);
    drain();
    repeat (20) @(posedge clk_i);
    if (sb.pending.size() != 0) begin
      sb.errors++;
      $display("%0d result words never arrived", sb.pending.size());
    end
    $display("covered %0d commands and %0d result words, %0d good builds, 4 idle patterns",
             sent, sb.checked, sb.builds_ok);
    $display("mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
